[sv/twa_pkg.sv]
// ----------------------------------------------------------------------------
// twa_pkg: shared types and constants of the temperature window alarm
// Widths, channel count, register indexes, cause codes and the per-channel
// state record that lives in the state RAM.
// ----------------------------------------------------------------------------
package twa_pkg;

  // Channel count and index width.
  localparam int NUM_CH = 4;
  localparam int CH_W   = 2;

  // Temperature and limit width (1/16 degree C counts).
  localparam int TEMP_W = 16;
  localparam int CNT_W  = 16;

  // Rate threshold in 1/16 degree C (0.25 degree C).
  localparam int DELTA_THRESHOLD = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMITS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_COUNTS = 2'd3;

  // Alarm cause codes.
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_OVER  = 2'd1;
  localparam logic [1:0] CAUSE_UNDER = 2'd2;
  localparam logic [1:0] CAUSE_FAULT = 2'd3;

  // One channel's state as stored in the RAM.
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic                     alarm;
    logic [1:0]               cause;
    logic signed [TEMP_W-1:0] prev_temp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of one read-modify-write step.
  typedef struct packed {
    entry_t nxt;
    logic   write;
    logic   rate_hit;
  } upd_t;

endpackage

[sv/twa_in_if.sv]
// ----------------------------------------------------------------------------
// twa_in_if: reading channel of the temperature window alarm
// Valid/ready handshake carrying one temperature reading per item.
// ----------------------------------------------------------------------------
interface twa_in_if;

  logic                                 valid;
  logic                                 ready;
  logic                                 scan_start;
  logic [twa_pkg::CH_W-1:0]             channel;
  logic signed [twa_pkg::TEMP_W-1:0]    temperature;
  logic                                 sensor_valid;

  modport source (
    output valid, scan_start, channel, temperature, sensor_valid,
    input  ready
  );

  modport sink (
    input  valid, scan_start, channel, temperature, sensor_valid,
    output ready
  );

endinterface

[sv/twa_out_if.sv]
// ----------------------------------------------------------------------------
// twa_out_if: result channel of the temperature window alarm
// Valid/ready handshake carrying one channel status item per reading.
// ----------------------------------------------------------------------------
interface twa_out_if;

  logic                       valid;
  logic                       ready;
  logic [twa_pkg::CH_W-1:0]   channel_out;
  logic                       channel_alarm;
  logic [1:0]                 alarm_cause;
  logic                       any_alarm;
  logic                       rate_exceeded;

  modport source (
    output valid, channel_out, channel_alarm, alarm_cause, any_alarm, rate_exceeded,
    input  ready
  );

  modport sink (
    input  valid, channel_out, channel_alarm, alarm_cause, any_alarm, rate_exceeded,
    output ready
  );

endinterface

[sv/twa_ram.sv]
// ----------------------------------------------------------------------------
// twa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. A read and a
// write of the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module twa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/twa_update.sv]
// ----------------------------------------------------------------------------
// twa_update: per-channel state update
// Window compare, saturating persistence counter, alarm and cause update,
// and the rate-of-change check against the stored previous reading.
// ----------------------------------------------------------------------------
module twa_update (
  input  twa_pkg::entry_t                 cur,
  input  logic                            ch_ok,
  input  logic                            enabled,
  input  logic signed [twa_pkg::TEMP_W-1:0] temperature,
  input  logic                            sensor_valid,
  input  logic signed [twa_pkg::TEMP_W-1:0] high_limit,
  input  logic signed [twa_pkg::TEMP_W-1:0] low_limit,
  input  logic [twa_pkg::CNT_W-1:0]       trig_count,
  output twa_pkg::upd_t                   upd
);

  logic                              over;
  logic                              under;
  logic [twa_pkg::CNT_W-1:0]         cnt_inc;
  logic signed [twa_pkg::TEMP_W:0]   diff;
  logic [twa_pkg::TEMP_W:0]          abs_diff;
  twa_pkg::entry_t                   nxt;

  // Window tests; the high test wins when the window is inverted.
  assign over  = temperature > high_limit;
  assign under = temperature < low_limit;

  // Saturating increment of the persistence counter.
  assign cnt_inc = (&cur.count) ? cur.count : cur.count + twa_pkg::CNT_W'(1);

  // Change from the previous reading, formed one bit wider so it is exact.
  assign diff     = {temperature[twa_pkg::TEMP_W-1], temperature}
                  - {cur.prev_temp[twa_pkg::TEMP_W-1], cur.prev_temp};
  assign abs_diff = diff[twa_pkg::TEMP_W] ? (twa_pkg::TEMP_W+1)'(-diff)
                                          : (twa_pkg::TEMP_W+1)'(diff);

  // Next entry: window logic only on enabled channels, the reading always.
  always_comb begin
    nxt = cur;
    if (enabled) begin
      if (over || under) begin
        nxt.count = cnt_inc;
        if (cnt_inc > trig_count) begin
          nxt.alarm = 1'b1;
          if (!sensor_valid) begin
            nxt.cause = twa_pkg::CAUSE_FAULT;
          end else if (over) begin
            nxt.cause = twa_pkg::CAUSE_OVER;
          end else begin
            nxt.cause = twa_pkg::CAUSE_UNDER;
          end
        end
      end else begin
        nxt.count = '0;
        nxt.alarm = 1'b0;
        nxt.cause = twa_pkg::CAUSE_NONE;
      end
    end
    nxt.prev_temp = temperature;
  end

  assign upd.nxt      = nxt;
  assign upd.write    = ch_ok;
  assign upd.rate_hit = ch_ok && enabled
                     && (abs_diff > (twa_pkg::TEMP_W+1)'(twa_pkg::DELTA_THRESHOLD));

endmodule

[sv/temperature_window_alarm.sv]
// ----------------------------------------------------------------------------
// temperature_window_alarm: windowed temperature alarm with persistence
// Per-channel counter, alarm, cause and previous reading live in a small
// state RAM that is read on item accept and written back when the update stage advances.
//
//   Channel   Dir   Handshake      Payload
//   in_ch     in    valid/ready    scan_start, channel, temperature, sensor_valid
//   out_ch    out   valid/ready    channel_out, channel_alarm, alarm_cause,
//                                  any_alarm, rate_exceeded
//   cfg_*     in    write enable   cfg_index, cfg_wdata (64 bits)
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the RAM read, then the update into the output register.
// A write-back is forwarded to the next item of the same channel, so items
// to one channel may follow back to back.
// Reset clears control state, config registers and per-entry valid bits; a
// RAM entry never written reads as all zero. No clearing pass is needed.
// A stalled result register holds the update stage, which in turn holds the
// input.
// ----------------------------------------------------------------------------
module temperature_window_alarm (
  input  logic                              clk,
  input  logic                              rst_n,
  twa_in_if.sink                            in_ch,
  twa_out_if.source                         out_ch,
  input  logic                              cfg_wr_en,
  input  logic [twa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [twa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CH_W   = twa_pkg::CH_W;
  localparam int NUM_CH = twa_pkg::NUM_CH;
  localparam int TW     = twa_pkg::TEMP_W;

  // Configuration registers.
  logic [NUM_CH-1:0]              en_mask_r;
  logic [twa_pkg::CFG_DATA_W-1:0] hi_pk_r;
  logic [twa_pkg::CFG_DATA_W-1:0] lo_pk_r;
  logic [twa_pkg::CFG_DATA_W-1:0] trig_pk_r;

  // Update stage.
  logic                  s1_vld_r;
  logic                  s1_scan_r;
  logic [CH_W-1:0]       s1_ch_r;
  logic signed [TW-1:0]  s1_temp_r;
  logic                  s1_sv_r;
  logic                  s1_ent_vld_r;
  logic                  s1_adv;
  logic                  s1_ch_ok;

  // Forwarding of the most recent write-back.
  logic                  fwd_vld_r;
  logic [CH_W-1:0]       fwd_addr_r;
  twa_pkg::entry_t       fwd_data_r;

  // State-level registers.
  logic [NUM_CH-1:0]     entry_vld_r;
  logic [NUM_CH-1:0]     alarm_vec_r;
  logic [NUM_CH-1:0]     alarm_vec_nxt;
  logic                  rate_r;
  logic                  rate_nxt;

  // Output register.
  logic                  out_vld_r;
  logic [CH_W-1:0]       out_ch_r;
  logic                  out_alarm_r;
  logic [1:0]            out_cause_r;
  logic                  out_any_r;
  logic                  out_rate_r;

  logic                  in_acc;
  logic                  out_take;
  logic [twa_pkg::ENTRY_W-1:0] ram_rdata;
  twa_pkg::entry_t       cur;
  twa_pkg::upd_t         upd;

  // Handshake control.
  assign out_take    = out_vld_r && out_ch.ready;
  assign s1_adv      = s1_vld_r && (!out_vld_r || out_take);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_ch_ok    = {1'b0, s1_ch_r} < (CH_W+1)'(NUM_CH);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_mask_r <= '0;
      hi_pk_r   <= '0;
      lo_pk_r   <= '0;
      trig_pk_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        twa_pkg::REG_ENABLE_MASK: en_mask_r <= cfg_wdata[NUM_CH-1:0];
        twa_pkg::REG_HIGH_LIMITS: hi_pk_r   <= cfg_wdata;
        twa_pkg::REG_LOW_LIMITS:  lo_pk_r   <= cfg_wdata;
        twa_pkg::REG_TRIG_COUNTS: trig_pk_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Channel state RAM.
  twa_ram #(
    .WIDTH (twa_pkg::ENTRY_W),
    .DEPTH (NUM_CH)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_adv && upd.write),
    .waddr (s1_ch_r),
    .wdata (upd.nxt),
    .re    (in_acc),
    .raddr (in_ch.channel),
    .rdata (ram_rdata)
  );

  // Current entry: latest write-back first, then RAM, then reset value.
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_ch_r)) begin
      cur = fwd_data_r;
    end else if (s1_ent_vld_r) begin
      cur = twa_pkg::entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  twa_update u_update (
    .cur          (cur),
    .ch_ok        (s1_ch_ok),
    .enabled      (en_mask_r[s1_ch_r]),
    .temperature  (s1_temp_r),
    .sensor_valid (s1_sv_r),
    .high_limit   (hi_pk_r[s1_ch_r*TW +: TW]),
    .low_limit    (lo_pk_r[s1_ch_r*TW +: TW]),
    .trig_count   (trig_pk_r[s1_ch_r*twa_pkg::CNT_W +: twa_pkg::CNT_W]),
    .upd          (upd)
  );

  // Alarm vector and rate flag after this item.
  always_comb begin
    alarm_vec_nxt = alarm_vec_r;
    if (upd.write) begin
      alarm_vec_nxt[s1_ch_r] = upd.nxt.alarm;
    end
    rate_nxt = (s1_scan_r ? 1'b0 : rate_r) | upd.rate_hit;
  end

  // Update stage capture on accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_scan_r    <= in_ch.scan_start;
      s1_ch_r      <= in_ch.channel;
      s1_temp_r    <= in_ch.temperature;
      s1_sv_r      <= in_ch.sensor_valid;
      s1_ent_vld_r <= entry_vld_r[in_ch.channel];
    end
  end

  // State-level updates and forwarding register on write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r   <= 1'b0;
      entry_vld_r <= '0;
      alarm_vec_r <= '0;
      rate_r      <= 1'b0;
    end else if (s1_adv) begin
      rate_r      <= rate_nxt;
      alarm_vec_r <= alarm_vec_nxt;
      if (upd.write) begin
        fwd_vld_r            <= 1'b1;
        entry_vld_r[s1_ch_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && upd.write) begin
      fwd_addr_r <= s1_ch_r;
      fwd_data_r <= upd.nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch_r    <= s1_ch_r;
      out_alarm_r <= s1_ch_ok ? upd.nxt.alarm : 1'b0;
      out_cause_r <= s1_ch_ok ? upd.nxt.cause : twa_pkg::CAUSE_NONE;
      out_any_r   <= |alarm_vec_nxt;
      out_rate_r  <= rate_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.channel_out   = out_ch_r;
  assign out_ch.channel_alarm = out_alarm_r;
  assign out_ch.alarm_cause   = out_cause_r;
  assign out_ch.any_alarm     = out_any_r;
  assign out_ch.rate_exceeded = out_rate_r;

  // The delivered alarm matches the alarm vector bit of that channel.
  a_alarm_vec: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_ch_ok |=> out_alarm_r == alarm_vec_r[out_ch_r])
    else $error("alarm vector disagrees with delivered alarm");

  // A blocked update stage keeps its item.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |=> s1_vld_r && $stable(s1_ch_r) && $stable(s1_temp_r))
    else $error("update stage lost its item while blocked");

  // Scan start without a new rate hit leaves the rate flag clear.
  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_scan_r && !upd.rate_hit |=> !rate_r && !out_rate_r)
    else $error("rate flag not cleared at scan start");

  // An accepted item always reaches the update stage.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted item missing from update stage");

endmodule
